// ===== rtl/rdsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdsm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  // star chains resolve one link per step, plus one for a plain anchor
  localparam int ITER_COUNT  = MAX_PATTERN / 2 + 1;
  localparam int CNT_W       = $clog2(ITER_COUNT + 1);

  localparam logic [7:0] SYM_DOT  = 8'd46;
  localparam logic [7:0] SYM_STAR = 8'd42;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;
  localparam logic [1:0] ACT_TEXT   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_DROP      = 2'd1;
  localparam logic [1:0] STAT_MALFORMED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       clear_work;
    logic       step;
    logic       commit;
    logic       clear_row;
    logic       text_mode;
    logic [7:0] text_char;
    logic [7:0] symbol;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rdsm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rdsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] symbol;

  modport source (output valid, output action, output symbol, input ready);
  modport sink   (input valid, input action, input symbol, output ready);
endinterface

`default_nettype wire

// ===== rtl/rdsm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rdsm_out_if;
  logic       valid;
  logic       ready;
  logic       match;
  logic [1:0] status;

  modport source (output valid, output match, output status, input ready);
  modport sink   (input valid, input match, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/regex_dot_star_matcher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Whole-text matcher for patterns with '.' (any byte) and '*' (zero or more of the
// previous symbol), up to MAX_PATTERN = 32 pattern bytes. Every input beat (clear
// pattern, append pattern byte, start text, text byte) returns exactly one result
// beat with match and status; one beat is in flight at a time. Clear, and an append
// into a full store, go from idle straight to the done state. Append, start and text
// bytes pass through the run state first: the row of pattern cells settles over
// MAX_PATTERN/2 + 1 steps, because a chain of starred symbols passes its bit one
// cell pair per clock. The next beat is taken as soon as the result is registered,
// even while that result still waits for the sink.
module regex_dot_star_matcher_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  rdsm_in_if.sink     in_i,
  rdsm_out_if.source  out_o
);
  import rdsm_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              malformed_q, malformed_d;
  logic              last_star_q, last_star_d;
  logic              drop_q, drop_d;
  logic              text_mode_q, text_mode_d;
  logic [7:0]        char_q, char_d;
  logic              row0_q, row0_d;
  logic              out_valid_q, out_valid_d;
  logic              out_match_q;
  logic [1:0]        out_status_q;

  logic              accept, full, is_append, write_sym, load_out, iter_done;
  cell_ctl_t         ctl;

  logic [MAX_PATTERN-1:0] we_vec;
  logic [MAX_PATTERN-1:0] act_vec;
  logic [MAX_PATTERN:0]   row_vec;
  logic [MAX_PATTERN+1:0] work_vec;
  logic [7:0]             sym_vec [MAX_PATTERN+1];

  assign full       = (len_q == LEN_W'(MAX_PATTERN));
  assign is_append  = (in_i.action == ACT_APPEND);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign iter_done  = (cnt_q == CNT_W'(ITER_COUNT));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((in_i.action == ACT_CLEAR) || (is_append && full)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (iter_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl.clear_work = 1'b0;
    ctl.step       = 1'b0;
    ctl.commit     = 1'b0;
    ctl.clear_row  = 1'b0;
    ctl.text_mode  = text_mode_q;
    ctl.text_char  = char_q;
    ctl.symbol     = in_i.symbol;
    write_sym      = 1'b0;
    load_out       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctl.clear_row  = (in_i.action == ACT_CLEAR);
          write_sym      = is_append && !full;
          ctl.clear_work = (in_i.action != ACT_CLEAR) && !(is_append && full);
        end
      end
      ST_RUN: begin
        ctl.step   = !iter_done;
        ctl.commit = iter_done;
      end
      ST_DONE: begin
        load_out = !out_valid_q || out_o.ready;
      end
      default: ;
    endcase
  end

  // item bookkeeping
  always_comb begin
    len_d       = len_q;
    malformed_d = malformed_q;
    last_star_d = last_star_q;
    drop_d      = drop_q;
    text_mode_d = text_mode_q;
    char_d      = char_q;
    row0_d      = row0_q;
    cnt_d       = cnt_q;
    if (accept) begin
      drop_d      = 1'b0;
      text_mode_d = 1'b0;
      cnt_d       = '0;
      unique case (in_i.action)
        ACT_CLEAR: begin
          len_d       = '0;
          malformed_d = 1'b0;
          last_star_d = 1'b0;
          row0_d      = 1'b1;
        end
        ACT_APPEND: begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            if ((in_i.symbol == SYM_STAR) && ((len_q == '0) || last_star_q)) begin
              malformed_d = 1'b1;
            end
            last_star_d = (in_i.symbol == SYM_STAR);
            len_d       = len_q + LEN_W'(1);
          end
        end
        ACT_START: ;
        ACT_TEXT: begin
          text_mode_d = 1'b1;
          char_d      = in_i.symbol;
        end
        default: ;
      endcase
    end else if (ctl.step) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctl.commit) begin
      row0_d = !text_mode_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      len_q       <= '0;
      malformed_q <= 1'b0;
      last_star_q <= 1'b0;
      drop_q      <= 1'b0;
      text_mode_q <= 1'b0;
      row0_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      malformed_q <= malformed_d;
      last_star_q <= last_star_d;
      drop_q      <= drop_d;
      text_mode_q <= text_mode_d;
      row0_q      <= row0_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (load_out) begin
      out_match_q <= !malformed_q && row_vec[len_q];
      if (drop_q) begin
        out_status_q <= STAT_DROP;
      end else if (malformed_q) begin
        out_status_q <= STAT_MALFORMED;
      end else begin
        out_status_q <= STAT_OK;
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.match  = out_match_q;
  assign out_o.status = out_status_q;

  // row of cells; index 0 of row_vec and sym_vec, and index 1 of work_vec, is the empty-prefix position
  assign row_vec[0]  = row0_q;
  assign work_vec[0] = 1'b0;
  assign work_vec[1] = !text_mode_q;
  assign sym_vec[0]  = 8'h00;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    assign we_vec[g]  = write_sym && (len_q == LEN_W'(g));
    assign act_vec[g] = (LEN_W'(g + 1) <= len_q);

    rdsm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .we_i         (we_vec[g]),
      .active_i     (act_vec[g]),
      .has_prev_i   (g != 0),
      .prev_sym_i   (sym_vec[g]),
      .row_prev_i   (row_vec[g]),
      .work_prev2_i (work_vec[g]),
      .sym_o        (sym_vec[g+1]),
      .row_o        (row_vec[g+1]),
      .work_o       (work_vec[g+2])
    );
  end

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_PATTERN))
    else $error("pattern length past store depth");

  a_row_above_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_vec & ~{act_vec, 1'b1}) == '0)
    else $error("row bit set above pattern length");

  a_malformed_no_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == STAT_MALFORMED) |-> !out_match_q)
    else $error("match reported on malformed pattern");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat without finished item");

  a_busy_no_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> (cnt_q != '0) || (state_q == ST_DONE))
    else $error("settle counter restarted mid item");

endmodule

`default_nettype wire

// ===== rtl/rdsm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdsm_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire rdsm_pkg::cell_ctl_t ctl_i,
  input  wire                   we_i,
  input  wire                   active_i,
  input  wire                   has_prev_i,
  input  wire  [7:0]            prev_sym_i,
  input  wire                   row_prev_i,
  input  wire                   work_prev2_i,
  output logic [7:0]            sym_o,
  output logic                  row_o,
  output logic                  work_o
);
  import rdsm_pkg::*;

  logic [7:0] sym_q;
  logic       row_q, row_d;
  logic       work_q, work_d;
  logic       is_star, hit_self, hit_prev, base, nxt;

  assign is_star  = (sym_q == SYM_STAR);
  assign hit_self = (sym_q == SYM_DOT) || (sym_q == ctl_i.text_char);
  assign hit_prev = (prev_sym_i == SYM_DOT) || (prev_sym_i == ctl_i.text_char);

  // base term from the old row; empty-row loads start from nothing
  always_comb begin
    if (!ctl_i.text_mode) begin
      base = 1'b0;
    end else if (is_star) begin
      base = has_prev_i && row_q && hit_prev;
    end else begin
      base = row_prev_i && hit_self;
    end
  end

  // a star also inherits the new bit two cells back
  assign nxt = is_star ? (has_prev_i && (work_prev2_i || base)) : base;

  always_comb begin
    work_d = work_q;
    if (ctl_i.clear_work) begin
      work_d = 1'b0;
    end else if (ctl_i.step) begin
      work_d = active_i && nxt;
    end
  end

  always_comb begin
    row_d = row_q;
    if (ctl_i.clear_row) begin
      row_d = 1'b0;
    end else if (ctl_i.commit) begin
      row_d = active_i && work_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= 1'b0;
      work_q <= 1'b0;
    end else begin
      row_q  <= row_d;
      work_q <= work_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      sym_q <= ctl_i.symbol;
    end
  end

  assign sym_o  = sym_q;
  assign row_o  = row_q;
  assign work_o = work_q;

endmodule

`default_nettype wire

// ===== sim/rdsm_match_checker.sv =====
`timescale 1ns / 1ps

module rdsm_match_checker
  import rdsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] in_action_i,
  input  logic [7:0] in_symbol_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       out_match_i,
  input  logic [1:0] out_status_i,
  output int         mismatch_count_o,
  output int         awaited_count_o
);

  typedef struct packed {
    logic       match;
    logic [1:0] status;
  } match_beat_t;

  logic [7:0]           pat_mem [MAX_PATTERN];
  int unsigned          pat_len;
  bit                   pat_bad;
  logic [MAX_PATTERN:0] row;
  match_beat_t          awaited_q [$];

  // row of the empty text: only star pairs can vanish
  function automatic void load_empty_row();
    row    = '0;
    row[0] = 1'b1;
    for (int j = 1; j <= pat_len; j++) begin
      if (pat_mem[j-1] == SYM_STAR && j >= 2) row[j] = row[j-2];
    end
  endfunction

  function automatic void advance_row(logic [7:0] c);
    logic [MAX_PATTERN:0] nxt;
    logic [7:0]           sym;
    logic                 hit;
    nxt = '0;
    for (int j = 1; j <= pat_len; j++) begin
      sym = pat_mem[j-1];
      if (sym == SYM_STAR) begin
        if (j >= 2) begin
          hit    = (pat_mem[j-2] == SYM_DOT) || (pat_mem[j-2] == c);
          nxt[j] = nxt[j-2] || (row[j] && hit);
        end
      end else begin
        nxt[j] = row[j-1] && (sym == SYM_DOT || sym == c);
      end
    end
    row = nxt;
  endfunction

  function automatic match_beat_t step_matcher(logic [1:0] act, logic [7:0] sym);
    match_beat_t r;
    logic [1:0]  st;
    st = STAT_OK;
    case (act)
      ACT_CLEAR: begin
        pat_len = 0;
        pat_bad = 1'b0;
        load_empty_row();
      end
      ACT_APPEND: begin
        if (pat_len >= MAX_PATTERN) begin
          st = STAT_DROP;
        end else begin
          if (sym == SYM_STAR && (pat_len == 0 || pat_mem[pat_len-1] == SYM_STAR))
            pat_bad = 1'b1;
          pat_mem[pat_len] = sym;
          pat_len++;
          load_empty_row();
        end
      end
      ACT_START: load_empty_row();
      default:   advance_row(sym);
    endcase
    if (st == STAT_OK && pat_bad) st = STAT_MALFORMED;
    r.match  = !pat_bad && row[pat_len];
    r.status = st;
    return r;
  endfunction

  task automatic report(string what, match_beat_t got, match_beat_t want);
    $display("%0t ns: %s mismatch: got match=%0b status=%0d, want match=%0b status=%0d",
             $time, what, got.match, got.status, want.match, want.status);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    match_beat_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PATTERN; i++) pat_mem[i] = '0;
      pat_len = 0;
      pat_bad = 1'b0;
      row     = '0;
      row[0]  = 1'b1;
      awaited_q.delete();
      mismatch_count_o = 0;
      awaited_count_o  <= 0;
    end else begin
      // the next input can be taken while the last result still waits; pop first, then push
      if (out_valid_i && out_ready_i) begin
        got.match  = out_match_i;
        got.status = out_status_i;
        if (awaited_q.size() == 0) begin
          report("unexpected result", got, '0);
        end else begin
          want = awaited_q.pop_front();
          if (got.match !== want.match) report("match", got, want);
          if (got.status !== want.status) report("status", got, want);
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_q.push_back(step_matcher(in_action_i, in_symbol_i));
      awaited_count_o <= awaited_q.size();
    end
  end

endmodule

// ===== sim/tb_regex_dot_star_matcher_core.sv =====
`timescale 1ns / 1ps

module tb_regex_dot_star_matcher_core;
  import rdsm_pkg::*;

  localparam int N_ITEMS     = 1650;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 25;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rdsm_in_if  in_if ();
  rdsm_out_if out_if ();

  int mismatches;
  int awaited;
  int n_sent;
  int idle_cycles;
  bit quiet;
  bit hold_req;

  always #5 clk = ~clk;

  regex_dot_star_matcher_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rdsm_match_checker match_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_if.valid),
    .in_ready_i       (in_if.ready),
    .in_action_i      (in_if.action),
    .in_symbol_i      (in_if.symbol),
    .out_valid_i      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .out_match_i      (out_if.match),
    .out_status_i     (out_if.status),
    .mismatch_count_o (mismatches),
    .awaited_count_o  (awaited)
  );

  // mostly short stalls, now and then a long one
  function automatic int stall_len();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int gap_len();
    if (quiet || $urandom_range(0, 99) < 55) return 0;
    return stall_len();
  endfunction

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 8'($urandom_range(0, 255));
    if (r < 25) return SYM_DOT;
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  task automatic send_beat(logic [1:0] act, logic [7:0] sym);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.symbol <= sym;
    do @(posedge clk); while (!in_if.ready);
    n_sent++;
  endtask

  task automatic send_text(int n);
    send_beat(ACT_START, 8'($urandom_range(0, 255)));
    repeat (n) send_beat(ACT_TEXT, text_char());
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet || $urandom_range(0, 99) < 60) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_if.ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** regex_dot_star_matcher_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int kind, plen, cnt;
    bit first_seq;
    bit hold_sent;
    in_if.valid  <= 1'b0;
    in_if.action <= ACT_CLEAR;
    in_if.symbol <= 8'h00;
    quiet     = 1'b1;
    hold_req  = 1'b0;
    hold_sent = 1'b0;
    n_sent    = 0;
    first_seq = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern: only the empty text matches
    send_beat(ACT_TEXT, "a");
    send_beat(ACT_START, 8'hFF);
    send_beat(ACT_APPEND, "a");
    send_beat(ACT_TEXT, "a");
    send_beat(ACT_TEXT, "a");
    // append restarts the text; "a*" matches the empty text
    send_beat(ACT_APPEND, SYM_STAR);
    send_beat(ACT_TEXT, "a");
    send_beat(ACT_TEXT, "b");
    send_beat(ACT_START, 8'h00);
    send_beat(ACT_TEXT, 8'hFF);
    send_beat(ACT_CLEAR, 8'hFF);
    send_beat(ACT_APPEND, SYM_DOT);
    send_beat(ACT_APPEND, SYM_STAR);
    send_beat(ACT_TEXT, 8'h00);
    send_beat(ACT_TEXT, 8'hFF);
    // leading star is malformed
    send_beat(ACT_CLEAR, 8'h00);
    send_beat(ACT_APPEND, SYM_STAR);
    send_beat(ACT_TEXT, SYM_STAR);
    // double star is malformed, sticky until clear
    send_beat(ACT_CLEAR, 8'h00);
    send_beat(ACT_APPEND, "x");
    send_beat(ACT_APPEND, SYM_STAR);
    send_beat(ACT_APPEND, SYM_STAR);
    send_beat(ACT_START, 8'h00);
    send_beat(ACT_CLEAR, 8'h00);
    send_beat(ACT_APPEND, 8'hFF);
    send_beat(ACT_TEXT, 8'hFF);

    while (n_sent < N_ITEMS) begin
      quiet = ($urandom_range(0, 99) < 15);
      if (!hold_sent && n_sent > 400) begin
        hold_req  = 1'b1;
        hold_sent = 1'b1;
      end
      kind = first_seq ? 80 : $urandom_range(0, 99);
      first_seq = 1'b0;
      if (kind < 70) begin
        // mostly well-formed pattern, then a few texts against it
        if ($urandom_range(0, 9) != 0) send_beat(ACT_CLEAR, 8'($urandom_range(0, 255)));
        plen = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 14);
        cnt = 0;
        while (cnt < plen) begin
          send_beat(ACT_APPEND, pattern_char());
          cnt++;
          if (cnt < plen && $urandom_range(0, 99) < 40) begin
            send_beat(ACT_APPEND, SYM_STAR);
            cnt++;
          end
        end
        repeat ($urandom_range(1, 3)) send_text($urandom_range(0, 8));
      end else if (kind < 80) begin
        // stars in random places, often malformed
        send_beat(ACT_CLEAR, 8'h00);
        repeat ($urandom_range(1, 6))
          send_beat(ACT_APPEND, ($urandom_range(0, 1) != 0) ? SYM_STAR : pattern_char());
        send_text($urandom_range(0, 4));
      end else if (kind < 85) begin
        // fill the store, then push bytes that get dropped
        send_beat(ACT_CLEAR, 8'h00);
        cnt = 0;
        while (cnt < MAX_PATTERN) begin
          send_beat(ACT_APPEND, pattern_char());
          cnt++;
          if (cnt < MAX_PATTERN && $urandom_range(0, 1) != 0) begin
            send_beat(ACT_APPEND, SYM_STAR);
            cnt++;
          end
        end
        repeat ($urandom_range(1, 3)) send_beat(ACT_APPEND, 8'($urandom_range(0, 255)));
        send_text($urandom_range(0, 6));
      end else begin
        // noise: any action, any byte
        repeat ($urandom_range(5, 15))
          send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("** regex_dot_star_matcher_core: PASSED **");
    end else begin
      $display("** regex_dot_star_matcher_core: FAILED **");
    end
    $finish;
  end

endmodule
